// ===== src/pwmtc_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// pwmtc_pkg
// Shared types, constants and the consensus function of the profile matrix unit.
// -----------------------------------------------------------------------------
package pwmtc_pkg;

   localparam int DEF_MAX_COLUMNS = 32;
   localparam int COUNT_W         = 16;
   localparam int NORM_W          = 10;
   localparam int SUM_W           = 18;
   localparam int DIVIDEND_W      = 26;
   localparam int SCORE_W         = 17;
   localparam int CSR_W           = 7;
   localparam int CODE_W          = 4;
   localparam int PER_MILLE       = 1000;
   localparam int PERCENT         = 100;
   localparam int CONS_SCALE      = 10;
   localparam logic [CSR_W-1:0] CUTOFF_RESET = 7'd85;

   localparam logic [CODE_W-1:0] CODE_A = 4'd0;
   localparam logic [CODE_W-1:0] CODE_W_IUPAC = 4'd4;
   localparam logic [CODE_W-1:0] CODE_B = 4'd10;
   localparam logic [CODE_W-1:0] CODE_N = 4'd14;

   typedef struct packed {
      logic [COUNT_W-1:0] count_a;
      logic [COUNT_W-1:0] count_c;
      logic [COUNT_W-1:0] count_g;
      logic [COUNT_W-1:0] count_t;
      logic               last_column;
   } req_item_type;

   typedef struct packed {
      logic [5:0]        position;
      logic [NORM_W-1:0] norm_a;
      logic [NORM_W-1:0] norm_c;
      logic [NORM_W-1:0] norm_g;
      logic [NORM_W-1:0] norm_t;
      logic [CODE_W-1:0] consensus_code;
      logic [15:0]       min_forward_score;
      logic [15:0]       min_reverse_score;
      logic [15:0]       max_score;
      logic [15:0]       cutoff_score;
      logic              last_result;
   } rsp_item_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   function automatic logic [15:0] sat16(input logic [SCORE_W-1:0] v);
      sat16 = (v > SCORE_W'(16'hFFFF)) ? 16'hFFFF : v[15:0];
   endfunction

   // Tiered IUPAC pick: single bases, then best double, then best triple, else n.
   function automatic logic [CODE_W-1:0] pick_code(input logic [NORM_W-1:0] wa,
                                                   input logic [NORM_W-1:0] wc,
                                                   input logic [NORM_W-1:0] wg,
                                                   input logic [NORM_W-1:0] wt,
                                                   input logic [10:0] cut);
      logic [11:0]       d [14];
      logic [11:0]       cx;
      logic [11:0]       best;
      logic [CODE_W-1:0] which;
      logic [CODE_W-1:0] code;
      logic              found;
      d[0]  = 12'(wa);
      d[1]  = 12'(wc);
      d[2]  = 12'(wg);
      d[3]  = 12'(wt);
      d[4]  = 12'(wa) + 12'(wt);
      d[5]  = 12'(wc) + 12'(wg);
      d[6]  = 12'(wc) + 12'(wt);
      d[7]  = 12'(wa) + 12'(wg);
      d[8]  = 12'(wa) + 12'(wc);
      d[9]  = 12'(wg) + 12'(wt);
      d[10] = 12'(wc) + 12'(wg) + 12'(wt);
      d[11] = 12'(wa) + 12'(wg) + 12'(wt);
      d[12] = 12'(wa) + 12'(wc) + 12'(wt);
      d[13] = 12'(wa) + 12'(wc) + 12'(wg);
      cx    = 12'(cut);
      code  = CODE_N;
      found = 1'b0;
      for (int k = 0; k < 4; k++) begin
         if (!found && d[k] >= cx) begin
            code  = CODE_A + CODE_W'(k);
            found = 1'b1;
         end
      end
      best  = '0;
      which = '0;
      for (int k = 4; k < 10; k++) begin
         if (d[k] > best && d[k] >= cx) begin
            best  = d[k];
            which = CODE_W'(k);
         end
      end
      if (!found && best != '0) begin
         code  = which;
         found = 1'b1;
      end
      best  = '0;
      which = '0;
      for (int k = 10; k < 14; k++) begin
         if (d[k] > best && d[k] >= cx) begin
            best  = d[k];
            which = CODE_W'(k);
         end
      end
      if (!found && best != '0) begin
         code = which;
      end
      pick_code = code;
   endfunction

endpackage

// ===== src/pwm_threshold_and_consensus_unit.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// pwm_threshold_and_consensus_unit
// Profile matrix loader with per-mille normalization, IUPAC consensus and
// forward / reverse-complement suffix score thresholds.
// -----------------------------------------------------------------------------
// Columns are taken one item per cycle while the unit is idle and stored in a
// column memory; columns beyond MAX_COLUMNS are dropped. The item marked last
// starts the run: each stored column goes through four divider lanes (one per
// base) side by side, each a 26-bit restoring division at one quotient bit per
// cycle. The cutoff score follows (register the product of total and percent,
// then divide by 100 through a reciprocal multiplication), then one result per
// column while the result side takes them; no new item is taken until the
// final result has been loaded into the output register.
// -----------------------------------------------------------------------------
module pwm_threshold_and_consensus_unit
   import pwmtc_pkg::*;
#(
   parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
)(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_item_type     req_item,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_item_type     rsp_item,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CSR_W-1:0] csr_data
);

   localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int CW = $clog2(MAX_COLUMNS + 1);

   // Divide by 100 as (x * ceil(2^30 / 100)) >> 30, exact for every product
   // of a total score and a percent that the unit can produce.
   localparam int               PROD_W      = SCORE_W + CSR_W;
   localparam int               WIDE_W      = 2 * PROD_W;
   localparam int               RECIP_SHIFT = 30;
   localparam logic [PROD_W-1:0] RECIP_100  = PROD_W'(10737419);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_NRD   = 4'd1;
   localparam logic [3:0] S_NLD   = 4'd2;
   localparam logic [3:0] S_NDIV  = 4'd3;
   localparam logic [3:0] S_CDIV  = 4'd4;
   localparam logic [3:0] S_CWAIT = 4'd5;
   localparam logic [3:0] S_ERD   = 4'd6;
   localparam logic [3:0] S_EOUT  = 4'd7;

   logic [3:0]         state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      pos_ff, pos_in;
   logic [SUM_W-1:0]   largest_ff, largest_in;
   logic [SCORE_W-1:0] total_ff, total_in;
   logic [SCORE_W-1:0] suffix_ff, suffix_in;
   logic [SCORE_W-1:0] cutoff_ff, cutoff_in;
   logic [PROD_W-1:0]  cut_prod_ff, cut_prod_in;
   logic [CSR_W-1:0]   cut_pct_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_item_ff, rsp_item_in;

   // Memories: columns, per-column weights with maximum, running prefix.
   logic [4*COUNT_W-1:0]  col_mem [MAX_COLUMNS];
   logic [5*NORM_W-1:0]   norm_mem [MAX_COLUMNS];
   logic [SCORE_W-1:0]    pre_mem [MAX_COLUMNS];
   logic [4*COUNT_W-1:0]  col_rd_ff;
   logic [5*NORM_W-1:0]   norm_rd_ff;
   logic [SCORE_W-1:0]    pre_rd_ff;

   logic                  accept;
   logic [SUM_W-1:0]      col_sum;
   logic                  lane_start;
   logic [DIVIDEND_W-1:0] lane_dividend [4];
   logic [SUM_W-1:0]      lane_divisor  [4];
   logic [DIVIDEND_W-1:0] lane_quo      [4];
   div_status_type        lane_status   [4];
   logic [NORM_W-1:0]     col_hi;
   logic [SCORE_W-1:0]    new_total;
   logic [CW-1:0]         rev_pos;
   logic [SCORE_W-1:0]    fwd_gap, rev_gap;
   logic [WIDE_W-1:0]     cut_scaled;
   logic                  out_free;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign col_sum   = SUM_W'(req_item.count_a) + SUM_W'(req_item.count_c)
                    + SUM_W'(req_item.count_g) + SUM_W'(req_item.count_t);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Divider lanes: one per base, all started together on the loaded column.
   assign lane_start = (state_ff == S_NLD);

   for (genvar j = 0; j < 4; j++) begin : g_lane
      assign lane_dividend[j] =
         DIVIDEND_W'(col_rd_ff[COUNT_W*j +: COUNT_W]) * DIVIDEND_W'(PER_MILLE);
      assign lane_divisor[j]  = largest_ff;
      pwmtc_div_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .start    (lane_start),
         .dividend (lane_dividend[j]),
         .divisor  (lane_divisor[j]),
         .status   (lane_status[j]),
         .quotient (lane_quo[j])
      );
   end

   pwmtc_merge u_merge (
      .w_a (lane_quo[0][NORM_W-1:0]),
      .w_c (lane_quo[1][NORM_W-1:0]),
      .w_g (lane_quo[2][NORM_W-1:0]),
      .w_t (lane_quo[3][NORM_W-1:0]),
      .hi  (col_hi)
   );

   assign new_total  = total_ff + SCORE_W'(col_hi);
   assign rev_pos    = count_ff - CW'(1) - pos_ff;
   assign fwd_gap    = (cutoff_ff > suffix_ff) ? cutoff_ff - suffix_ff : '0;
   assign rev_gap    = (cutoff_ff > pre_rd_ff) ? cutoff_ff - pre_rd_ff : '0;
   assign cut_scaled = WIDE_W'(cut_prod_ff) * WIDE_W'(RECIP_100);

   // Sequencer: store, normalize column by column, scale the cutoff, emit.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      largest_in   = largest_ff;
      total_in     = total_ff;
      suffix_in    = suffix_ff;
      cutoff_in    = cutoff_ff;
      cut_prod_in  = cut_prod_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_item_in  = rsp_item_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (count_ff < CW'(MAX_COLUMNS)) begin
                  count_in = count_ff + CW'(1);
                  if (col_sum > largest_ff) begin
                     largest_in = col_sum;
                  end
               end
               if (req_item.last_column) begin
                  pos_in   = '0;
                  total_in = '0;
                  state_in = S_NRD;
               end
            end
         end
         S_NRD: begin
            state_in = S_NLD;
         end
         S_NLD: begin
            state_in = S_NDIV;
         end
         S_NDIV: begin
            if (lane_status[0].done) begin
               total_in = new_total;
               if (pos_ff + CW'(1) == count_ff) begin
                  state_in = S_CDIV;
               end else begin
                  pos_in   = pos_ff + CW'(1);
                  state_in = S_NRD;
               end
            end
         end
         S_CDIV: begin
            cut_prod_in = PROD_W'(total_ff) * PROD_W'(cut_pct_ff);
            state_in    = S_CWAIT;
         end
         S_CWAIT: begin
            cutoff_in = cut_scaled[RECIP_SHIFT +: SCORE_W];
            suffix_in = total_ff;
            pos_in    = '0;
            state_in  = S_ERD;
         end
         S_ERD: begin
            state_in = S_EOUT;
         end
         S_EOUT: begin
            if (out_free) begin
               rsp_valid_in                   = 1'b1;
               rsp_item_in.position           = 6'(pos_ff);
               rsp_item_in.norm_a             = norm_rd_ff[0*NORM_W +: NORM_W];
               rsp_item_in.norm_c             = norm_rd_ff[1*NORM_W +: NORM_W];
               rsp_item_in.norm_g             = norm_rd_ff[2*NORM_W +: NORM_W];
               rsp_item_in.norm_t             = norm_rd_ff[3*NORM_W +: NORM_W];
               rsp_item_in.consensus_code     = pick_code(
                  norm_rd_ff[0*NORM_W +: NORM_W], norm_rd_ff[1*NORM_W +: NORM_W],
                  norm_rd_ff[2*NORM_W +: NORM_W], norm_rd_ff[3*NORM_W +: NORM_W],
                  11'(cut_pct_ff) * 11'(CONS_SCALE));
               rsp_item_in.min_forward_score  = sat16(fwd_gap);
               rsp_item_in.min_reverse_score  = sat16(rev_gap);
               rsp_item_in.max_score          = sat16(total_ff);
               rsp_item_in.cutoff_score       = sat16(cutoff_ff);
               rsp_item_in.last_result        = (pos_ff + CW'(1) == count_ff);
               suffix_in = suffix_ff - SCORE_W'(norm_rd_ff[4*NORM_W +: NORM_W]);
               if (pos_ff + CW'(1) == count_ff) begin
                  // End of run: drop the column count and the largest sum.
                  count_in   = '0;
                  largest_in = '0;
                  state_in   = S_IDLE;
               end else begin
                  pos_in   = pos_ff + CW'(1);
                  state_in = S_ERD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         largest_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         cut_pct_ff   <= CUTOFF_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         largest_ff   <= largest_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            cut_pct_ff <= csr_data;
         end
      end
      pos_ff      <= pos_in;
      total_ff    <= total_in;
      suffix_ff   <= suffix_in;
      cutoff_ff   <= cutoff_in;
      cut_prod_ff <= cut_prod_in;
      rsp_item_ff <= rsp_item_in;
   end

   // Memory ports.
   always_ff @(posedge clock) begin
      if (accept && count_ff < CW'(MAX_COLUMNS)) begin
         col_mem[count_ff[AW-1:0]] <= {req_item.count_t, req_item.count_g,
                                       req_item.count_c, req_item.count_a};
      end
      col_rd_ff <= col_mem[pos_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_NDIV && lane_status[0].done) begin
         norm_mem[pos_ff[AW-1:0]] <= {col_hi, lane_quo[3][NORM_W-1:0],
                                      lane_quo[2][NORM_W-1:0], lane_quo[1][NORM_W-1:0],
                                      lane_quo[0][NORM_W-1:0]};
         pre_mem[pos_ff[AW-1:0]]  <= new_total;
      end
      norm_rd_ff <= norm_mem[pos_ff[AW-1:0]];
      pre_rd_ff  <= pre_mem[rev_pos[AW-1:0]];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ===== src/pwmtc_div_lane.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// pwmtc_div_lane
// Restoring divider lane, one quotient bit per cycle; zero divisor gives zero.
// -----------------------------------------------------------------------------
module pwmtc_div_lane
   import pwmtc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [SUM_W-1:0]      divisor,
   output div_status_type        status,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W);

   logic [SUM_W:0]        rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [SUM_W-1:0]      dsr_ff;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [SUM_W:0]        trial;

   assign trial = {rem_ff[SUM_W-1:0], quo_ff[DIVIDEND_W-1]};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = trial - {1'b0, dsr_ff};
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         dsr_ff <= divisor;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = (dsr_ff == '0) ? '0 : quo_ff;

endmodule

// ===== src/pwmtc_merge.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// pwmtc_merge
// Combine the four lane weights: pick the column maximum.
// -----------------------------------------------------------------------------
module pwmtc_merge
   import pwmtc_pkg::*;
(
   input  logic [NORM_W-1:0] w_a,
   input  logic [NORM_W-1:0] w_c,
   input  logic [NORM_W-1:0] w_g,
   input  logic [NORM_W-1:0] w_t,
   output logic [NORM_W-1:0] hi
);

   logic [NORM_W-1:0] hi_ac, hi_gt;

   assign hi_ac = (w_c > w_a) ? w_c : w_a;
   assign hi_gt = (w_t > w_g) ? w_t : w_g;
   assign hi    = (hi_gt > hi_ac) ? hi_gt : hi_ac;

endmodule
